FILE: rtl/ptd_pkg.sv
// Shared constants and types for the point-to-triangle distance pipeline.
// No dependencies; the top level, ptd_div and ptd_sqrt import this package.
`default_nettype none

package ptd_pkg;

  localparam int COORD_WIDTH_DEF = 24;   // default coordinate width
  localparam int N_COORD         = 12;   // coordinates in one input transfer
  localparam int QBITS           = 32;   // fraction bits of the barycentric parameters
  localparam int DIST_W          = 25;   // width of the distance result
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam int OUT_DW          = ((DIST_W + 7) / 8) * 8;
  localparam int MUL_LAT         = 3;    // register stages of the wide multiplier

  // How a barycentric parameter is formed once the region is known.
  typedef enum logic [1:0] {
    PAR_ZERO,
    PAR_ONE,
    PAR_DIV,
    PAR_COMP
  } par_sel_t;

endpackage

`default_nettype wire

FILE: rtl/point_triangle_distance_core.sv
// Point-to-triangle distance core: top level.
// Depends on ptd_pkg, ptd_dly, ptd_mul, ptd_div and ptd_sqrt.
//
// One input transfer carries a query point and three triangle vertices as
// twelve signed coordinates. One output transfer carries the floor of the
// Euclidean distance from the point to the closest point of the triangle in
// tdata, and in tuser a flag that is set when the point projects into the
// interior of a triangle of zero area; the distance is then taken to the
// first vertex.
//
// The core takes one transfer in every cycle unless it stalls as described
// below. A result may also wait in the output buffer before it leaves; the
// pipeline's length is set mainly by the 33-stage divider that forms the
// barycentric parameters and by the 25-stage square root.
//
// A two-entry output buffer sits behind the pipeline, so input is still
// taken while one finished result waits. Only when both entries are full and
// the receiver holds tready low does the whole pipeline stall, losing
// nothing. Reset clears all valid bits and the output buffer.
`default_nettype none

module point_triangle_distance_core
  import ptd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // query_x, query_y, query_z, vert0_x..z, vert1_x..z, vert2_x..z, low bits up
  input  logic [((N_COORD*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // min_distance, zero filled above
  output logic [OUT_DW-1:0]                          out_tdata,
  // degenerate
  output logic [0:0]                                 out_tuser
);

  localparam int CW      = COORD_WIDTH;
  localparam int DIF     = CW + 1;
  localparam int PW      = 2 * DIF;
  localparam int DW      = PW + 2;
  localparam int QW      = 2 * DW + 1;
  localparam int NW      = QW;
  localparam int PARW    = QBITS + 1;
  localparam int PR      = PARW + 1 + DIF;
  localparam int RW      = DIF + QBITS + 3;
  localparam int XW      = 2 * RW + 2;
  localparam int YW      = XW - 2 * QBITS;
  localparam int YX      = (YW > 2 * DIST_W) ? YW : 2 * DIST_W + 1;
  localparam int LAT_DIV = QBITS + 1;
  localparam int GEO_D   = MUL_LAT + LAT_DIV + 5;
  localparam int DEG_D   = LAT_DIV + 4 + MUL_LAT + DIST_W;
  localparam int LAT     = 3 + MUL_LAT + 2 + LAT_DIV + 3 + MUL_LAT + 1 + DIST_W;
  localparam logic [PARW-1:0] P_ONE = PARW'(1) << QBITS;

  // ---------------------------------------------------------------- control
  logic           en;
  logic [LAT-1:0] vld_r;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;

  assign en        = (cnt_r != 2'd2) | out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [CW-1:0]  fld [N_COORD];
  logic signed [DIF-1:0] e0_r [3];
  logic signed [DIF-1:0] e1_r [3];
  logic signed [DIF-1:0] dv_r [3];

  for (genvar j = 0; j < N_COORD; j++) begin : g_fld
    assign fld[j] = $signed(in_tdata[j*CW +: CW]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i] <= DIF'(fld[6+i]) - DIF'(fld[3+i]);
        e1_r[i] <= DIF'(fld[9+i]) - DIF'(fld[3+i]);
        dv_r[i] <= DIF'(fld[3+i]) - DIF'(fld[i]);
      end
    end
  end

  // ------------------------------------------------ stages 2, 3: dot products
  logic signed [DIF-1:0] opa [15];
  logic signed [DIF-1:0] opb [15];
  logic signed [PW-1:0]  prd_r [15];
  logic signed [DW-1:0]  a_r, b_r, c_r, d_r, e_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[i]    = e0_r[i];  opb[i]    = e0_r[i];
      opa[3+i]  = e0_r[i];  opb[3+i]  = e1_r[i];
      opa[6+i]  = e1_r[i];  opb[6+i]  = e1_r[i];
      opa[9+i]  = e0_r[i];  opb[9+i]  = dv_r[i];
      opa[12+i] = e1_r[i];  opb[12+i] = dv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 15; k++) begin
        prd_r[k] <= opa[k] * opb[k];
      end
      a_r <= DW'(prd_r[0])  + DW'(prd_r[1])  + DW'(prd_r[2]);
      b_r <= DW'(prd_r[3])  + DW'(prd_r[4])  + DW'(prd_r[5]);
      c_r <= DW'(prd_r[6])  + DW'(prd_r[7])  + DW'(prd_r[8]);
      d_r <= DW'(prd_r[9])  + DW'(prd_r[10]) + DW'(prd_r[11]);
      e_r <= DW'(prd_r[12]) + DW'(prd_r[13]) + DW'(prd_r[14]);
    end
  end

  // ------------------------------------------- wide products for det, sn, tn
  logic signed [2*DW-1:0] m_ac, m_bb, m_be, m_cd, m_bd, m_ae;
  logic [5*DW-1:0]        dot_d;
  logic signed [DW-1:0]   a_d, b_d, c_d, d_d, e_d;

  ptd_mul #(.W(DW)) u_mul_ac (.clk(clk), .en(en), .a_i(a_r), .b_i(c_r), .p_o(m_ac));
  ptd_mul #(.W(DW)) u_mul_bb (.clk(clk), .en(en), .a_i(b_r), .b_i(b_r), .p_o(m_bb));
  ptd_mul #(.W(DW)) u_mul_be (.clk(clk), .en(en), .a_i(b_r), .b_i(e_r), .p_o(m_be));
  ptd_mul #(.W(DW)) u_mul_cd (.clk(clk), .en(en), .a_i(c_r), .b_i(d_r), .p_o(m_cd));
  ptd_mul #(.W(DW)) u_mul_bd (.clk(clk), .en(en), .a_i(b_r), .b_i(d_r), .p_o(m_bd));
  ptd_mul #(.W(DW)) u_mul_ae (.clk(clk), .en(en), .a_i(a_r), .b_i(e_r), .p_o(m_ae));

  ptd_dly #(.WIDTH(5*DW), .DEPTH(MUL_LAT)) u_dly_dot (
    .clk(clk), .en(en), .d_i({e_r, d_r, c_r, b_r, a_r}), .q_o(dot_d)
  );

  assign a_d = $signed(dot_d[0*DW +: DW]);
  assign b_d = $signed(dot_d[1*DW +: DW]);
  assign c_d = $signed(dot_d[2*DW +: DW]);
  assign d_d = $signed(dot_d[3*DW +: DW]);
  assign e_d = $signed(dot_d[4*DW +: DW]);

  // ---------------------------------------------------------------- stage 7
  logic signed [QW-1:0] det_r, sn_r, tn_r;
  logic signed [DW+1:0] hden_r;
  logic signed [DW:0]   bd_r, ce_r, be_r, ad_r;
  logic signed [DW-1:0] a7_r, c7_r, d7_r, e7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r  <= QW'(m_ac) - QW'(m_bb);
      sn_r   <= QW'(m_be) - QW'(m_cd);
      tn_r   <= QW'(m_bd) - QW'(m_ae);
      hden_r <= (DW+2)'(a_d) - ((DW+2)'(b_d) <<< 1) + (DW+2)'(c_d);
      bd_r   <= (DW+1)'(b_d) + (DW+1)'(d_d);
      ce_r   <= (DW+1)'(c_d) + (DW+1)'(e_d);
      be_r   <= (DW+1)'(b_d) + (DW+1)'(e_d);
      ad_r   <= (DW+1)'(a_d) + (DW+1)'(d_d);
      a7_r   <= a_d;
      c7_r   <= c_d;
      d7_r   <= d_d;
      e7_r   <= e_d;
    end
  end

  // ---------------------------------------------- stage 8: region selection
  par_sel_t      s_sel_nxt, t_sel_nxt, s_sel_r, t_sel_r;
  logic [NW-1:0] s_num_nxt, s_den_nxt, t_num_nxt, t_den_nxt;
  logic [NW-1:0] s_num_r, s_den_r, t_num_r, t_den_r;
  logic          degen_nxt, degen_r;

  always_comb begin
    logic signed [QW:0]   stsum;
    logic                 in_tri;
    logic signed [DW:0]   nd, ne;
    logic signed [DW+1:0] hs_num, ht_num;
    logic                 sn_neg, tn_neg, d_neg, e_neg;

    stsum  = (QW+1)'(sn_r) + (QW+1)'(tn_r);
    in_tri = (stsum <= (QW+1)'(det_r));
    nd     = -((DW+1)'(d7_r));
    ne     = -((DW+1)'(e7_r));
    hs_num = (DW+2)'(ce_r) - (DW+2)'(bd_r);
    ht_num = (DW+2)'(ad_r) - (DW+2)'(be_r);
    sn_neg = sn_r[QW-1];
    tn_neg = tn_r[QW-1];
    d_neg  = d7_r[DW-1];
    e_neg  = e7_r[DW-1];

    s_sel_nxt = PAR_ZERO;
    t_sel_nxt = PAR_ZERO;
    degen_nxt = 1'b0;
    s_num_nxt = NW'(nd);
    s_den_nxt = NW'(a7_r);
    t_num_nxt = NW'(ne);
    t_den_nxt = NW'(c7_r);

    if (in_tri) begin
      if (sn_neg) begin
        if (tn_neg && d_neg) begin
          s_sel_nxt = PAR_DIV;
        end else if (e_neg) begin
          t_sel_nxt = PAR_DIV;
        end
      end else if (tn_neg) begin
        if (d_neg) begin
          s_sel_nxt = PAR_DIV;
        end
      end else if (det_r == '0) begin
        degen_nxt = 1'b1;
      end else begin
        s_sel_nxt = PAR_DIV;
        t_sel_nxt = PAR_DIV;
        s_num_nxt = NW'(sn_r);
        s_den_nxt = NW'(det_r);
        t_num_nxt = NW'(tn_r);
        t_den_nxt = NW'(det_r);
      end
    end else begin
      if (sn_neg) begin
        if (ce_r > bd_r) begin
          s_sel_nxt = PAR_DIV;
          t_sel_nxt = PAR_COMP;
          s_num_nxt = NW'(hs_num);
          s_den_nxt = NW'(hden_r);
        end else if (ce_r[DW] || (ce_r == '0)) begin
          t_sel_nxt = PAR_ONE;
        end else if (e_neg) begin
          t_sel_nxt = PAR_DIV;
        end
      end else if (tn_neg) begin
        if (ad_r > be_r) begin
          t_sel_nxt = PAR_DIV;
          s_sel_nxt = PAR_COMP;
          t_num_nxt = NW'(ht_num);
          t_den_nxt = NW'(hden_r);
        end else if (ad_r[DW] || (ad_r == '0)) begin
          s_sel_nxt = PAR_ONE;
        end else if (d_neg) begin
          s_sel_nxt = PAR_DIV;
        end
      end else begin
        if (hs_num[DW+1] || (hs_num == '0)) begin
          t_sel_nxt = PAR_ONE;
        end else begin
          s_sel_nxt = PAR_DIV;
          t_sel_nxt = PAR_COMP;
          s_num_nxt = NW'(hs_num);
          s_den_nxt = NW'(hden_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sel_r <= s_sel_nxt;
      t_sel_r <= t_sel_nxt;
      s_num_r <= s_num_nxt;
      s_den_r <= s_den_nxt;
      t_num_r <= t_num_nxt;
      t_den_r <= t_den_nxt;
      degen_r <= degen_nxt;
    end
  end

  // --------------------------------------------------------------- dividers
  logic [PARW-1:0] qs, qt;
  logic [3:0]      sel_d;
  par_sel_t        s_sel_d, t_sel_d;

  ptd_div #(.NW(NW), .QB(QBITS)) u_div_s (
    .clk(clk), .en(en), .num_i(s_num_r), .den_i(s_den_r), .quo_o(qs)
  );
  ptd_div #(.NW(NW), .QB(QBITS)) u_div_t (
    .clk(clk), .en(en), .num_i(t_num_r), .den_i(t_den_r), .quo_o(qt)
  );

  ptd_dly #(.WIDTH(4), .DEPTH(LAT_DIV)) u_dly_sel (
    .clk(clk), .en(en), .d_i({t_sel_r, s_sel_r}), .q_o(sel_d)
  );

  assign s_sel_d = par_sel_t'(sel_d[1:0]);
  assign t_sel_d = par_sel_t'(sel_d[3:2]);

  // ------------------------------------------------- parameter clamp stage
  logic [PARW-1:0] s_r, t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (s_sel_d)
        PAR_ZERO: s_r <= '0;
        PAR_ONE:  s_r <= P_ONE;
        PAR_DIV:  s_r <= qs;
        PAR_COMP: s_r <= P_ONE - qt;
        default:  s_r <= '0;
      endcase
      unique case (t_sel_d)
        PAR_ZERO: t_r <= '0;
        PAR_ONE:  t_r <= P_ONE;
        PAR_DIV:  t_r <= qt;
        PAR_COMP: t_r <= P_ONE - qs;
        default:  t_r <= '0;
      endcase
    end
  end

  // -------------------------------------------------------------- residual
  logic [9*DIF-1:0]      geo_pk, geo_d;
  logic signed [PR-1:0]  ps_r [3];
  logic signed [PR-1:0]  pt_r [3];
  logic signed [DIF-1:0] dv1_r [3];
  logic signed [RW-1:0]  r_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geo_pk[i*DIF +: DIF]     = e0_r[i];
      geo_pk[(3+i)*DIF +: DIF] = e1_r[i];
      geo_pk[(6+i)*DIF +: DIF] = dv_r[i];
    end
  end

  ptd_dly #(.WIDTH(9*DIF), .DEPTH(GEO_D)) u_dly_geo (
    .clk(clk), .en(en), .d_i(geo_pk), .q_o(geo_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ps_r[i]  <= $signed({1'b0, s_r}) * $signed(geo_d[i*DIF +: DIF]);
        pt_r[i]  <= $signed({1'b0, t_r}) * $signed(geo_d[(3+i)*DIF +: DIF]);
        dv1_r[i] <= $signed(geo_d[(6+i)*DIF +: DIF]);
        r_r[i]   <= (RW'(dv1_r[i]) <<< QBITS) + RW'(ps_r[i]) + RW'(pt_r[i]);
      end
    end
  end

  // ------------------------------------------- squared length and the root
  logic signed [2*RW-1:0] sq [3];
  logic signed [XW-1:0]   xs;
  logic [YX-1:0]          y_ext;
  logic [2*DIST_W-1:0]    y_r;
  logic                   sat_r, sat_d, degen_d;
  logic [DIST_W-1:0]      root;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    ptd_mul #(.W(RW)) u_mul_sq (
      .clk(clk), .en(en), .a_i(r_r[i]), .b_i(r_r[i]), .p_o(sq[i])
    );
  end

  assign xs    = XW'(sq[0]) + XW'(sq[1]) + XW'(sq[2]);
  assign y_ext = YX'(xs[XW-1:2*QBITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      y_r   <= y_ext[2*DIST_W-1:0];
      sat_r <= |y_ext[YX-1:2*DIST_W];
    end
  end

  ptd_sqrt #(.W(DIST_W)) u_sqrt (
    .clk(clk), .en(en), .rad_i(y_r), .root_o(root)
  );

  ptd_dly #(.WIDTH(1), .DEPTH(DIST_W)) u_dly_sat (
    .clk(clk), .en(en), .d_i(sat_r), .q_o(sat_d)
  );
  ptd_dly #(.WIDTH(1), .DEPTH(DEG_D)) u_dly_deg (
    .clk(clk), .en(en), .d_i(degen_r), .q_o(degen_d)
  );

  // ---------------------------------------------------------- output buffer
  logic [DIST_W:0] res_new, slot0_r, slot1_r;

  assign res_new = {degen_d, sat_d ? DIST_MAX : root};
  assign push    = vld_r[LAT-1] & en;
  assign pop     = out_tready & (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0_r <= (cnt_r == 2'd2) ? slot1_r : res_new;
    end else if (push && (cnt_r == 2'd0)) begin
      slot0_r <= res_new;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      slot1_r <= res_new;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = OUT_DW'(slot0_r[DIST_W-1:0]);
  assign out_tuser  = slot0_r[DIST_W];

  // ------------------------------------------------------------ assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (out_tvalid && (cnt_r == 2'd2)))
    else $error("pipeline stalled without a full output buffer");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && (vld_r == '0)))
    else $error("valid state not cleared by reset");

endmodule

`default_nettype wire

FILE: rtl/ptd_dly.sv
// Delay line with a common enable, used to carry side data past long units.
// Depends on nothing but the clock and enable of the surrounding pipeline.
`default_nettype none

module ptd_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/ptd_mul.sv
// Signed W x W multiplier cut into four half-width partial products over
// three register stages. Depends on no other file.
`default_nettype none

module ptd_mul #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int L = W / 2;
  localparam int H = W - L;

  logic [L-1:0]          alo, blo;
  logic signed [H-1:0]   ahi, bhi;
  logic [2*L-1:0]        pll_r;
  logic signed [L+H:0]   plh_r, phl_r;
  logic signed [2*H-1:0] phh_r;
  logic signed [L+H+1:0] mid_r;
  logic signed [2*W-1:0] hl_r, p_r;

  assign alo = a_i[L-1:0];
  assign ahi = a_i[W-1:L];
  assign blo = b_i[L-1:0];
  assign bhi = b_i[W-1:L];

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= alo * blo;
      plh_r <= $signed({1'b0, alo}) * bhi;
      phl_r <= ahi * $signed({1'b0, blo});
      phh_r <= ahi * bhi;
      // The low product is non-negative and fills its slot exactly, so the
      // outer terms simply sit side by side.
      mid_r <= (L+H+2)'(plh_r) + (L+H+2)'(phl_r);
      hl_r  <= {phh_r, pll_r};
      p_r   <= hl_r + ((2*W)'(mid_r) <<< L);
    end
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

FILE: rtl/ptd_div.sv
// Pipelined restoring divider giving a QB-bit fraction num/den, or exactly
// one when num >= den. Depends on ptd_pkg for the default fraction width.
`default_nettype none

module ptd_div
  import ptd_pkg::*;
#(
  parameter int NW = 64,
  parameter int QB = QBITS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic [QB:0]   quo_o
);

  logic [NW-1:0] rem_r [QB+1];
  logic [NW-1:0] den_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [QB:0]   ge_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_i;
      den_r[0] <= den_i;
      quo_r[0] <= '0;
      ge_r[0]  <= (num_i >= den_i);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NW:0] tr, diff;
    logic        take;

    assign tr   = {rem_r[k-1], 1'b0};
    assign diff = tr - {1'b0, den_r[k-1]};
    assign take = (tr >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? diff[NW-1:0] : tr[NW-1:0];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= {quo_r[k-1][QB-2:0], take};
        ge_r[k]  <= ge_r[k-1];
      end
    end
  end

  assign quo_o = ge_r[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_r[QB]};

endmodule

`default_nettype wire

FILE: rtl/ptd_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on ptd_pkg for the default result width.
`default_nettype none

module ptd_sqrt
  import ptd_pkg::*;
#(
  parameter int W = DIST_W
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  logic [W:0]     rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rad_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]     rem_p;
    logic [W-1:0]   root_p;
    logic [2*W-1:0] rad_p;
    logic [W+2:0]   cat, trial;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end

    assign cat   = {rem_p, rad_p[2*W-1:2*W-2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        // The remainder can reach twice the partial root, so it keeps W+1 bits.
        rem_r[k]  <= take ? (W+1)'(cat - trial) : cat[W:0];
        root_r[k] <= {root_p[W-2:0], take};
        rad_r[k]  <= {rad_p[2*W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_r[W-1];

endmodule

`default_nettype wire
